// ----- hdl/fptc_pkg.sv -----
// ----------------------------------------------------------------------------
// fptc_pkg
// shared constants and types for the binary64 tolerant compare
// ----------------------------------------------------------------------------
package fptc_pkg;

	// three-way order codes
	typedef enum logic [1:0] {
		ORD_LESS    = 2'd0,
		ORD_EQUAL   = 2'd1,
		ORD_GREATER = 2'd2
	} ord_t;

	// binary64 field widths
	localparam int EXP_W  = 11;
	localparam int FRAC_W = 52;
	localparam int SIG_W  = FRAC_W + 1;

	// tolerance factor 1e-15: significand with hidden one, exponent 2^-102 per lsb
	localparam logic [SIG_W-1:0] TOL_SIG = 53'h1203AF9EE75616;

	// pipeline depth from transaction accept to result strobe
	localparam int LATENCY = 7;

endpackage

// ----- hdl/fp64_tolerant_compare.sv -----
// ----------------------------------------------------------------------------
// fp64_tolerant_compare
// pipelined three-way compare of two binary64 values with relative tolerance
// ----------------------------------------------------------------------------
// Takes one operand pair per clock and returns one order code per pair,
// marked by a single-cycle done strobe; busy is always low, so a transaction
// may be started in every cycle. The result cannot be held off: the receiver
// must take it in the cycle that done is high. The seven stages are set by
// the rounded subtract (align, add, leading zero count, normalize, round)
// running beside a split 53x53 multiply by the tolerance factor, with the
// final 64-bit compare of the two rounded values in the last stage. NaN
// sorts above all values, two NaNs are equal, and infinities order by sign;
// finite values are equal when the rounded |left - right| does not exceed
// the rounded 1e-15 * max(|left|, |right|).
module fp64_tolerant_compare (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] left_bits,
	input  logic [63:0] right_bits,
	output logic        done,
	output logic [1:0]  order
);

	localparam int EW = fptc_pkg::EXP_W;
	localparam int SW = fptc_pkg::SIG_W;

	// never stalls
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// stage 1: classify, order magnitudes, unpack
	// ------------------------------------------------------------------
	logic          l_nan, r_nan, l_inf, r_inf, a_ge;
	logic [63:0]   x_c, y_c;
	fptc_pkg::ord_t sp_ord_c;
	logic          sp_c;

	always_comb begin
		l_nan = (&left_bits[62:52]) && (|left_bits[51:0]);
		r_nan = (&right_bits[62:52]) && (|right_bits[51:0]);
		l_inf = (&left_bits[62:52]) && !(|left_bits[51:0]);
		r_inf = (&right_bits[62:52]) && !(|right_bits[51:0]);
		sp_c = l_nan || r_nan || l_inf || r_inf;
		priority if (l_nan || r_nan) begin
			sp_ord_c = (l_nan && r_nan) ? fptc_pkg::ORD_EQUAL :
				(l_nan ? fptc_pkg::ORD_GREATER : fptc_pkg::ORD_LESS);
		end else if (l_inf && r_inf) begin
			sp_ord_c = (left_bits[63] == right_bits[63]) ? fptc_pkg::ORD_EQUAL :
				(left_bits[63] ? fptc_pkg::ORD_LESS : fptc_pkg::ORD_GREATER);
		end else if (l_inf) begin
			sp_ord_c = left_bits[63] ? fptc_pkg::ORD_LESS : fptc_pkg::ORD_GREATER;
		end else if (r_inf) begin
			sp_ord_c = right_bits[63] ? fptc_pkg::ORD_GREATER : fptc_pkg::ORD_LESS;
		end else begin
			sp_ord_c = fptc_pkg::ORD_EQUAL;
		end
		// larger magnitude goes to x; it also feeds the tolerance product
		a_ge = left_bits[62:0] >= right_bits[62:0];
		x_c  = a_ge ? left_bits : right_bits;
		y_c  = a_ge ? right_bits : left_bits;
	end

	logic              v_s1, sp_s1, neg_s1, sub_s1;
	fptc_pkg::ord_t    sp_ord_s1;
	logic [EW-1:0]     xe_s1, ye_s1;
	logic [SW-1:0]     xm_s1, ym_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sp_s1     <= sp_c;
		sp_ord_s1 <= sp_ord_c;
		// sign of the difference when it is not zero
		neg_s1    <= a_ge ? left_bits[63] : ~right_bits[63];
		sub_s1    <= left_bits[63] == right_bits[63];
		xe_s1     <= (x_c[62:52] == '0) ? EW'(1) : x_c[62:52];
		ye_s1     <= (y_c[62:52] == '0) ? EW'(1) : y_c[62:52];
		xm_s1     <= {(x_c[62:52] != '0), x_c[51:0]};
		ym_s1     <= {(y_c[62:52] != '0), y_c[51:0]};
	end

	// ------------------------------------------------------------------
	// stage 2: align smaller operand, partial products of the bound
	// ------------------------------------------------------------------
	logic [EW-1:0] dexp;
	logic [5:0]    d6;
	logic [55:0]   ym_ext, ya_raw, ya_c;
	logic          ya_st;

	always_comb begin
		dexp   = xe_s1 - ye_s1;
		d6     = dexp[5:0];
		ym_ext = {ym_s1, 3'b000};
		if (dexp >= EW'(56)) begin
			ya_raw = '0;
			ya_st  = |ym_s1;
		end else begin
			ya_raw = ym_ext >> d6;
			ya_st  = |(ym_ext & ((56'd1 << d6) - 56'd1));
		end
		ya_c = {ya_raw[55:1], ya_raw[0] | ya_st};
	end

	logic              v_s2, sp_s2, neg_s2, sub_s2;
	fptc_pkg::ord_t    sp_ord_s2;
	logic [EW-1:0]     xe_s2;
	logic [SW-1:0]     xm_s2;
	logic [55:0]       ya_s2;
	logic [51:0]       pp_hh_s2;
	logic [52:0]       pp_hl_s2, pp_lh_s2;
	logic [53:0]       pp_ll_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sp_s2     <= sp_s1;
		sp_ord_s2 <= sp_ord_s1;
		neg_s2    <= neg_s1;
		sub_s2    <= sub_s1;
		xe_s2     <= xe_s1;
		xm_s2     <= xm_s1;
		ya_s2     <= ya_c;
		pp_hh_s2  <= 52'(xm_s1[52:27] * fptc_pkg::TOL_SIG[52:27]);
		pp_hl_s2  <= 53'(xm_s1[52:27] * fptc_pkg::TOL_SIG[26:0]);
		pp_lh_s2  <= 53'(xm_s1[26:0] * fptc_pkg::TOL_SIG[52:27]);
		pp_ll_s2  <= 54'(xm_s1[26:0] * fptc_pkg::TOL_SIG[26:0]);
	end

	// ------------------------------------------------------------------
	// stage 3: add or subtract magnitudes, sum partial products
	// ------------------------------------------------------------------
	logic              v_s3, sp_s3, neg_s3;
	fptc_pkg::ord_t    sp_ord_s3;
	logic [EW-1:0]     xe_s3;
	logic [56:0]       sum_s3;
	logic [105:0]      prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sp_s3     <= sp_s2;
		sp_ord_s3 <= sp_ord_s2;
		neg_s3    <= neg_s2;
		xe_s3     <= xe_s2;
		sum_s3    <= sub_s2 ? ({1'b0, xm_s2, 3'b000} - {1'b0, ya_s2}) :
			({1'b0, xm_s2, 3'b000} + {1'b0, ya_s2});
		prod_s3   <= ({54'd0, pp_hh_s2} << 54) +
			({52'd0, 54'({1'b0, pp_hl_s2} + {1'b0, pp_lh_s2})} << 27) +
			{52'd0, pp_ll_s2};
	end

	// ------------------------------------------------------------------
	// stage 4: leading zero count, bound shift and exponent
	// ------------------------------------------------------------------
	logic [5:0]    lz_c;
	logic [6:0]    t_c, sh_c;
	logic [EW-1:0] base_c;

	always_comb begin
		lz_c = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (sum_s3[i]) begin
				lz_c = 6'(55 - i);
			end
		end
		// product leading one sits at bit 105 or 104 for a normal max
		t_c = prod_s3[105] ? 7'd53 : 7'd52;
		if (xe_s3 <= EW'(50)) begin
			// bound lands in the subnormal range
			sh_c   = 7'(EW'(103) - xe_s3);
			base_c = '0;
		end else begin
			sh_c   = t_c;
			base_c = xe_s3 + EW'(t_c) - EW'(103);
		end
	end

	logic              v_s4, sp_s4, neg_s4;
	fptc_pkg::ord_t    sp_ord_s4;
	logic [EW-1:0]     xe_s4, base_s4;
	logic [56:0]       sum_s4;
	logic [105:0]      prod_s4;
	logic [5:0]        lz_s4;
	logic [6:0]        sh_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sp_s4     <= sp_s3;
		sp_ord_s4 <= sp_ord_s3;
		neg_s4    <= neg_s3;
		xe_s4     <= xe_s3;
		sum_s4    <= sum_s3;
		prod_s4   <= prod_s3;
		lz_s4     <= lz_c;
		sh_s4     <= sh_c;
		base_s4   <= base_c;
	end

	// ------------------------------------------------------------------
	// stage 5: normalize difference, shift product down to its quantum
	// ------------------------------------------------------------------
	logic [EW-1:0] nsh_c, ne_c;
	logic [55:0]   nrm_c;
	logic [105:0]  pq_full, pmask;
	logic          pg_c, pst_c;

	always_comb begin
		nsh_c = '0;
		if (sum_s4[56]) begin
			nrm_c = {sum_s4[56:2], sum_s4[1] | sum_s4[0]};
			ne_c  = xe_s4 + EW'(1);
		end else begin
			// left shift stops at the minimum exponent for subnormal results
			nsh_c = (EW'(lz_s4) < (xe_s4 - EW'(1))) ? EW'(lz_s4) : (xe_s4 - EW'(1));
			nrm_c = sum_s4[55:0] << nsh_c[5:0];
			ne_c  = xe_s4 - nsh_c;
		end
		pq_full = prod_s4 >> sh_s4;
		pg_c    = prod_s4[sh_s4 - 7'd1];
		pmask   = (106'd1 << (sh_s4 - 7'd1)) - 106'd1;
		pst_c   = |(prod_s4 & pmask);
	end

	logic              v_s5, sp_s5, neg_s5, pg_s5, pst_s5;
	fptc_pkg::ord_t    sp_ord_s5;
	logic [EW-1:0]     ne_s5, base_s5;
	logic [55:0]       nrm_s5;
	logic [53:0]       pq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sp_s5     <= sp_s4;
		sp_ord_s5 <= sp_ord_s4;
		neg_s5    <= neg_s4;
		ne_s5     <= ne_c;
		nrm_s5    <= nrm_c;
		pq_s5     <= pq_full[53:0];
		pg_s5     <= pg_c;
		pst_s5    <= pst_c;
		base_s5   <= base_s4;
	end

	// ------------------------------------------------------------------
	// stage 6: round to nearest even, pack both values as bit patterns
	// ------------------------------------------------------------------
	logic [53:0] dm_c, bm_c;
	logic [63:0] dpat_c, bpat_c;

	always_comb begin
		dm_c = {1'b0, nrm_s5[55:3]} +
			54'(nrm_s5[2] & (nrm_s5[1] | nrm_s5[0] | nrm_s5[3]));
		bm_c = pq_s5 + 54'(pg_s5 & (pst_s5 | pq_s5[0]));
		// hidden one carries into the exponent field; overflow lands at or past inf
		dpat_c = {1'b0, ne_s5 - EW'(1), 52'd0} + {10'd0, dm_c};
		bpat_c = {1'b0, base_s5, 52'd0} + {10'd0, bm_c};
	end

	logic              v_s6, sp_s6, neg_s6;
	fptc_pkg::ord_t    sp_ord_s6;
	logic [63:0]       dpat_s6, bpat_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		sp_s6     <= sp_s5;
		sp_ord_s6 <= sp_ord_s5;
		neg_s6    <= neg_s5;
		dpat_s6   <= dpat_c;
		bpat_s6   <= bpat_c;
	end

	// ------------------------------------------------------------------
	// stage 7: compare |diff| against bound, register the result
	// ------------------------------------------------------------------
	fptc_pkg::ord_t ord_c;

	always_comb begin
		priority if (sp_s6) begin
			ord_c = sp_ord_s6;
		end else if (dpat_s6 <= bpat_s6) begin
			ord_c = fptc_pkg::ORD_EQUAL;
		end else begin
			ord_c = neg_s6 ? fptc_pkg::ORD_LESS : fptc_pkg::ORD_GREATER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		order <= ord_c;
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(fptc_pkg::LATENCY) done)
		else $error("transaction lost in pipeline");

	a_no_ghost : assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##(fptc_pkg::LATENCY) !done)
		else $error("result without transaction");

	a_code : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (order == fptc_pkg::ORD_LESS || order == fptc_pkg::ORD_EQUAL ||
			order == fptc_pkg::ORD_GREATER))
		else $error("undefined order code");

	a_nan_left : assert property (@(posedge clk) disable iff (!arst_n)
		(start && (&left_bits[62:52]) && (|left_bits[51:0]) &&
			!((&right_bits[62:52]) && (|right_bits[51:0])))
		|-> ##(fptc_pkg::LATENCY) (order == fptc_pkg::ORD_GREATER))
		else $error("nan on left must order greater");

	a_self_equal : assert property (@(posedge clk) disable iff (!arst_n)
		(start && (left_bits == right_bits))
		|-> ##(fptc_pkg::LATENCY) (order == fptc_pkg::ORD_EQUAL))
		else $error("identical operands must compare equal");

endmodule
